>>> hdl/lce_pkg.sv
// shared types and constants for the lru cache with expiry
package lce_pkg;

    typedef logic [31:0] word_t;
    typedef logic [1:0]  state_t;

    localparam state_t S_IDLE   = 2'd0;
    localparam state_t S_SCAN   = 2'd1;
    localparam state_t S_DECIDE = 2'd2;
    localparam state_t S_UPDATE = 2'd3;

    localparam logic  OP_LOOKUP = 1'b0;
    localparam logic  OP_INSERT = 1'b1;

    localparam word_t TTL_RESET = 32'd300;

endpackage

>>> hdl/lce_ram.sv
// generic simple dual-port ram with one write port and a registered read port
module lce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/lru_cache_with_expiry_top.sv
// top level of the fully associative lru cache with expiry age
//
// command channel: a beat is taken at a rising edge with start high and busy
// low; operation, key, value_in and now_tick are sampled there. busy stays high
// until the command is finished.
// result channel: done is high for exactly one cycle with hit, value_out and
// evicted; the receiver cannot stall it, so no result is ever held back.
// configuration: cfg_we writes cfg_wdata into the ttl register at any edge;
// it is meant to be written while busy is low.
// all entries live in one ram word each (key, stamp, value, rank) with a
// registered read, and every command scans the ram one entry per cycle.
// lookup: a scan of every entry, then the decide state; done follows in the next
// cycle, with the block back in idle and able to take a new command.
// insert: the same scan, then a second pass over every entry that writes the
// target entry with rank zero and raises the rank of the valid entries it moves ahead of.
// reset clears the valid bits, the state machine, done and sets ttl to 300;
// the ram needs no clearing pass since only valid entries are ever used.
module lru_cache_with_expiry_top #(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic signed [31:0] key,
    input  logic        [31:0] value_in,
    input  logic        [31:0] now_tick,
    input  logic               cfg_we,
    input  logic        [31:0] cfg_wdata,
    output logic               done,
    output logic               hit,
    output logic        [31:0] value_out,
    output logic               evicted
);

    localparam int IB        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RB        = IB;
    localparam int SB        = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int RANK_LSB  = 0;
    localparam int VAL_LSB   = RB;
    localparam int STAMP_LSB = RB + SB;
    localparam int KEY_LSB   = RB + SB + 32;
    localparam int WB        = RB + SB + 64;

    localparam logic [IB-1:0] LAST_IDX = IB'(ENTRIES - 1);

    lce_pkg::state_t     state_reg, state_next;
    logic [IB-1:0]       idx_reg, idx_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    lce_pkg::word_t      ttl_reg, ttl_next;
    logic                done_reg, done_next;

    logic                op_reg, op_next;
    lce_pkg::word_t      key_reg, key_next;
    logic [SB-1:0]       val_reg, val_next;
    lce_pkg::word_t      now_reg, now_next;
    logic                found_reg, found_next;
    logic [IB-1:0]       slot_reg, slot_next;
    lce_pkg::word_t      fstamp_reg, fstamp_next;
    logic [SB-1:0]       fvalue_reg, fvalue_next;
    logic [RB-1:0]       frank_reg, frank_next;
    logic                free_found_reg, free_found_next;
    logic [IB-1:0]       free_reg, free_next;
    logic [RB-1:0]       max_rank_reg, max_rank_next;
    logic [IB-1:0]       victim_reg, victim_next;
    logic [IB-1:0]       target_reg, target_next;
    logic                age_all_reg, age_all_next;
    logic                hit_reg, hit_next;
    lce_pkg::word_t      value_out_reg, value_out_next;
    logic                evicted_reg, evicted_next;

    logic                ram_we;
    logic [IB-1:0]       ram_waddr;
    logic [WB-1:0]       ram_wdata;
    logic                ram_re;
    logic [IB-1:0]       ram_raddr;
    logic [WB-1:0]       rd_word;

    lce_pkg::word_t      rd_key;
    logic [RB-1:0]       rd_rank;
    logic                cur_valid;
    lce_pkg::word_t      age;
    logic [IB-1:0]       tgt;

    lce_ram #(
        .WIDTH (WB),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_word)
    );

    assign rd_key    = rd_word[KEY_LSB +: 32];
    assign rd_rank   = rd_word[RANK_LSB +: RB];
    assign cur_valid = valid_reg[idx_reg];
    assign age       = now_reg - fstamp_reg;
    assign tgt       = found_reg ? slot_reg : (free_found_reg ? free_reg : victim_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        ttl_next        = cfg_we ? cfg_wdata : ttl_reg;
        done_next       = 1'b0;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        now_next        = now_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        fstamp_next     = fstamp_reg;
        fvalue_next     = fvalue_reg;
        frank_next      = frank_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        max_rank_next   = max_rank_reg;
        victim_next     = victim_reg;
        target_next     = target_reg;
        age_all_next    = age_all_reg;
        hit_next        = hit_reg;
        value_out_next  = value_out_reg;
        evicted_next    = evicted_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = rd_word;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            lce_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next         = operation;
                    key_next        = key;
                    val_next        = value_in[SB-1:0];
                    now_next        = now_tick;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    max_rank_next   = '0;
                    victim_next     = '0;
                    idx_next        = '0;
                    ram_re          = 1'b1;
                    ram_raddr       = '0;
                    state_next      = lce_pkg::S_SCAN;
                end
            end
            lce_pkg::S_SCAN:
            begin
                if (cur_valid && (rd_key == key_reg))
                begin
                    found_next  = 1'b1;
                    slot_next   = idx_reg;
                    fstamp_next = rd_word[STAMP_LSB +: 32];
                    fvalue_next = rd_word[VAL_LSB +: SB];
                    frank_next  = rd_rank;
                end
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_next       = idx_reg;
                end
                if (cur_valid && (rd_rank >= max_rank_reg))
                begin
                    max_rank_next = rd_rank;
                    victim_next   = idx_reg;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = lce_pkg::S_DECIDE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            lce_pkg::S_DECIDE:
            begin
                done_next = 1'b1;
                if (op_reg == lce_pkg::OP_LOOKUP)
                begin
                    hit_next       = found_reg && (age <= ttl_reg);
                    value_out_next = (found_reg && (age <= ttl_reg)) ? 32'(fvalue_reg) : '0;
                    evicted_next   = 1'b0;
                    state_next     = lce_pkg::S_IDLE;
                end
                else
                begin
                    hit_next        = found_reg;
                    value_out_next  = '0;
                    evicted_next    = !found_reg && !free_found_reg;
                    target_next     = tgt;
                    age_all_next    = !found_reg;
                    valid_next[tgt] = 1'b1;
                    idx_next        = '0;
                    ram_re          = 1'b1;
                    ram_raddr       = '0;
                    state_next      = lce_pkg::S_UPDATE;
                end
            end
            lce_pkg::S_UPDATE:
            begin
                ram_we = 1'b1;
                if (idx_reg == target_reg)
                begin
                    ram_wdata = {key_reg, now_reg, val_reg, {RB{1'b0}}};
                end
                else if (cur_valid && (age_all_reg || (rd_rank < frank_reg)))
                begin
                    ram_wdata = {rd_word[WB-1:RB], rd_rank + 1'b1};
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = lce_pkg::S_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = lce_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lce_pkg::S_IDLE;
            valid_reg <= '0;
            ttl_reg   <= lce_pkg::TTL_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            ttl_reg   <= ttl_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        now_reg        <= now_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        fstamp_reg     <= fstamp_next;
        fvalue_reg     <= fvalue_next;
        frank_reg      <= frank_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
        max_rank_reg   <= max_rank_next;
        victim_reg     <= victim_next;
        target_reg     <= target_next;
        age_all_reg    <= age_all_next;
        hit_reg        <= hit_next;
        value_out_reg  <= value_out_next;
        evicted_reg    <= evicted_next;
    end

    assign busy      = (state_reg != lce_pkg::S_IDLE);
    assign done      = done_reg;
    assign hit       = hit_reg;
    assign value_out = value_out_reg;
    assign evicted   = evicted_reg;

    // a result beat never stretches: done is dropped again after it
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // an eviction only happens on an insert of a new key
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && evicted_reg) |-> (!hit_reg && (value_out_reg == '0)))
        else $error("eviction reported together with a hit or a value");

    // the victim path is taken only when every entry is valid
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lce_pkg::S_DECIDE) && (op_reg == lce_pkg::OP_INSERT) &&
         !found_reg && !free_found_reg) |-> (&valid_reg))
        else $error("eviction while a free entry exists");

    // the scan never changes which entries are valid
    a_scan_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lce_pkg::S_SCAN) |=> $stable(valid_reg))
        else $error("valid bits changed during the scan");

    // an accepted command makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

endmodule

>>> tb/lce_reply_checker.sv
// checker that tracks the cache contents and compares every result beat
module lce_reply_checker #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        operation,
    input  logic [31:0] key,
    input  logic [31:0] value_in,
    input  logic [31:0] now_tick,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        done,
    input  logic        hit,
    input  logic [31:0] value_out,
    input  logic        evicted,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic           hit;
        lce_pkg::word_t value;
        logic           evicted;
    } reply_t;

    lce_pkg::word_t ttl;
    lce_pkg::word_t slot_key[ENTRIES];
    lce_pkg::word_t slot_value[ENTRIES];
    lce_pkg::word_t slot_stamp[ENTRIES];
    logic           slot_valid[ENTRIES];
    int             slot_rank[ENTRIES];
    reply_t         expected_replies[$];

    function automatic reply_t access_cache(logic op, lce_pkg::word_t k, lce_pkg::word_t v,
                                            lce_pkg::word_t t);
        reply_t         r;
        int             slot;
        int             target;
        int             worst;
        lce_pkg::word_t age;
        r = '0;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && slot_valid[i] && slot_key[i] == k)
                slot = i;
        if (op == lce_pkg::OP_LOOKUP)
        begin
            if (slot >= 0)
            begin
                age = t - slot_stamp[slot];
                if (age <= ttl)
                begin
                    r.hit   = 1'b1;
                    r.value = slot_value[slot];
                end
            end
        end
        else if (slot >= 0)
        begin
            r.hit = 1'b1;
            slot_value[slot] = v;
            slot_stamp[slot] = t;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && slot_rank[i] < slot_rank[slot])
                    slot_rank[i]++;
            slot_rank[slot] = 0;
        end
        else
        begin
            target = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (target < 0 && !slot_valid[i])
                    target = i;
            if (target < 0)
            begin
                // full: the least recent entry carries the largest rank
                worst  = 0;
                target = 0;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_rank[i] >= worst)
                    begin
                        worst  = slot_rank[i];
                        target = i;
                    end
                slot_valid[target] = 1'b0;
                r.evicted = 1'b1;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i])
                    slot_rank[i]++;
            slot_key[target]   = k;
            slot_value[target] = v;
            slot_stamp[target] = t;
            slot_valid[target] = 1'b1;
            slot_rank[target]  = 0;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        reply_t want;
        if (!rst_n)
        begin
            ttl = lce_pkg::TTL_RESET;
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 0;
            end
            expected_replies.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        mismatches++;
                    end
                    if (value_out !== want.value)
                    begin
                        $error("value_out: expected %08h, got %08h", want.value, value_out);
                        mismatches++;
                    end
                    if (evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0d, got %0d", want.evicted, evicted);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                expected_replies.insert(expected_replies.size(),
                                        access_cache(operation, key, value_in, now_tick));
            if (cfg_we)
                ttl = cfg_wdata;
        end
        outstanding = expected_replies.size();
    end

endmodule

>>> tb/lru_cache_with_expiry_top_tb.sv
// testbench top: drives commands and ttl writes into the lru cache and gives the verdict
module lru_cache_with_expiry_top_tb;

    localparam int ENTRIES     = 16;
    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 110;
    localparam int POOL_KEYS   = 20;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           operation = lce_pkg::OP_LOOKUP;
    logic [31:0]    key = '0;
    logic [31:0]    value_in = '0;
    logic [31:0]    now_tick = '0;
    logic           cfg_we = 1'b0;
    logic [31:0]    cfg_wdata = '0;
    logic           busy;
    logic           done;
    logic           hit;
    logic [31:0]    value_out;
    logic           evicted;

    int             mismatches;
    int             outstanding;
    int             idle_cycles = 0;
    logic           burst = 1'b0;
    lce_pkg::word_t tick = '0;
    lce_pkg::word_t key_pool[POOL_KEYS];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    lru_cache_with_expiry_top #(
        .ENTRIES   (ENTRIES),
        .VALUE_BITS(32)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operation(operation),
        .key      (key),
        .value_in (value_in),
        .now_tick (now_tick),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .done     (done),
        .hit      (hit),
        .value_out(value_out),
        .evicted  (evicted)
    );

    lce_reply_checker #(
        .ENTRIES(ENTRIES)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .key        (key),
        .value_in   (value_in),
        .now_tick   (now_tick),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .hit        (hit),
        .value_out  (value_out),
        .evicted    (evicted),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic issue(input logic op, input lce_pkg::word_t k, input lce_pkg::word_t v,
                         input lce_pkg::word_t t);
        int gap;
        if ($urandom_range(0, 19) == 0)
            burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        operation = op;
        key       = k;
        value_in  = v;
        now_tick  = t;
        start     = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain_commands();
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_ttl(input lce_pkg::word_t v);
        drain_commands();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic advance_tick();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            tick = tick + $urandom_range(0, 60);
        else if (pick == 8)
            tick = $urandom;
        else if (pick == 9)
            tick = tick - $urandom_range(1, 50);
    endtask

    initial
    begin
        logic           op;
        lce_pkg::word_t k;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // empty cache, extreme keys and values, expiry boundary, wrapped ages, eviction when full
        issue(lce_pkg::OP_LOOKUP, 32'h0000_0000, $urandom, 32'd0);
        issue(lce_pkg::OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 32'd0);
        issue(lce_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0000, 32'd0);
        issue(lce_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678, 32'hffff_ffff);
        issue(lce_pkg::OP_INSERT, 32'hffff_ffff, 32'h5a5a_5a5a, 32'd100);
        issue(lce_pkg::OP_LOOKUP, 32'h7fff_ffff, $urandom, 32'd300);
        issue(lce_pkg::OP_LOOKUP, 32'h7fff_ffff, $urandom, 32'd301);
        issue(lce_pkg::OP_LOOKUP, 32'h0000_0000, $urandom, 32'd0);
        issue(lce_pkg::OP_LOOKUP, 32'hffff_ffff, $urandom, 32'd50);
        issue(lce_pkg::OP_INSERT, 32'h7fff_ffff, 32'ha5a5_a5a5, 32'd400);
        issue(lce_pkg::OP_LOOKUP, 32'h7fff_ffff, $urandom, 32'd400);
        for (int i = 1; i <= 12; i++)
            issue(lce_pkg::OP_INSERT, lce_pkg::word_t'(i), $urandom, 32'd500);
        issue(lce_pkg::OP_INSERT, 32'd13, $urandom, 32'd500);
        issue(lce_pkg::OP_LOOKUP, 32'h8000_0000, $urandom, 32'd500);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1: write_ttl(32'd0);
                2: write_ttl(32'hffff_ffff);
                3: write_ttl($urandom_range(0, 200));
                4: write_ttl($urandom);
                5: write_ttl(lce_pkg::TTL_RESET);
                default: ;
            endcase
            for (int i = 0; i < POOL_KEYS; i++)
                key_pool[i] = $urandom;
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7fff_ffff;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                op = ($urandom_range(0, 9) < 4) ? lce_pkg::OP_INSERT : lce_pkg::OP_LOOKUP;
                k  = ($urandom_range(0, 9) == 0) ? $urandom
                                                 : key_pool[$urandom_range(0, POOL_KEYS - 1)];
                advance_tick();
                issue(op, k, $urandom, tick);
            end
        end

        drain_commands();
        repeat (2 * ENTRIES + 4) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
